// File: hw/rtl/ecmp_apsp_pkg.sv
// Shared types and codes for the ECMP all-pairs shortest path block.
`timescale 1ns / 1ps
`default_nettype none

package ecmp_apsp_pkg;

  // Request operation codes
  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_RUN   = 2'd2,
    OP_QUERY = 2'd3
  } op_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_SW_RD1,
    ST_SW_RD2,
    ST_SW_UPD,
    ST_QRY_RD,
    ST_QRY_OUT
  } state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic cap_req;   // latch the accepted request
    logic cnt_clr;   // zero the k, i, j counters
    logic step_ij;   // advance i, j (clearing pass)
    logic step_kij;  // advance k, i, j (sweep)
    logic clr_wr;    // write the reset value of pair (i, j)
    logic ld_wr;     // write the loaded link
    logic rd_pair1;  // read d[i][k] and d[k][j]
    logic rd_pair2;  // capture the candidate sum, read d[i][j] and its mask
    logic upd_wr;    // relax pair (i, j) through k
    logic out_load;  // load the query result register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    op_e  op;        // latched operation
    logic skip;      // current triple has i, j, k not distinct
    logic last_ij;   // i and j both at their last node
    logic last_kij;  // k, i and j all at their last node
  } sts_t;

endpackage

`default_nettype wire

// File: hw/rtl/ecmp_apsp_ctrl.sv
// Controller state machine: sequences clear, load, sweep and query requests.
`timescale 1ns / 1ps
`default_nettype none

module ecmp_apsp_ctrl
  import ecmp_apsp_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // State and result-valid registers; reset starts the clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.last_ij) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.step_ij = 1'b1;
        end
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.cap_req = 1'b1;
          cmd_o.cnt_clr = 1'b1;
          state_d       = ST_LOAD;
        end
      end
      ST_LOAD: begin
        // dispatch on the latched operation
        case (sts_i.op)
          OP_CLEAR: state_d = ST_CLEAR;
          OP_LOAD: begin
            cmd_o.ld_wr = 1'b1;
            state_d     = ST_IDLE;
          end
          OP_RUN:   state_d = ST_SW_RD1;
          OP_QUERY: state_d = ST_QRY_RD;
          default:  state_d = ST_IDLE;
        endcase
      end
      ST_SW_RD1: begin
        cmd_o.rd_pair1 = 1'b1;
        if (!sts_i.skip) begin
          state_d = ST_SW_RD2;
        end else if (sts_i.last_kij) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.step_kij = 1'b1;
        end
      end
      ST_SW_RD2: begin
        cmd_o.rd_pair2 = 1'b1;
        state_d        = ST_SW_UPD;
      end
      ST_SW_UPD: begin
        cmd_o.upd_wr = 1'b1;
        if (sts_i.last_kij) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.step_kij = 1'b1;
          state_d        = ST_SW_RD1;
        end
      end
      ST_QRY_RD: begin
        state_d = ST_QRY_OUT;
      end
      ST_QRY_OUT: begin
        // hold until the result register is free
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Result valid: set on load, drop once taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// File: hw/rtl/ecmp_apsp_dpath.sv
// Datapath: distance and mask memories, node counters, relaxation and result registers.
`timescale 1ns / 1ps
`default_nettype none

module ecmp_apsp_dpath
  import ecmp_apsp_pkg::*;
#(
  parameter int unsigned NODES      = 16,
  parameter int unsigned DIST_WIDTH = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [1:0]        operation_i,
  input  wire logic [3:0]        src_node_i,
  input  wire logic [3:0]        dst_node_i,
  input  wire logic [15:0]       link_weight_i,
  input  wire cmd_t              cmd_i,
  output sts_t                   sts_o,
  output logic [31:0]            distance_o,
  output logic [15:0]            transit_mask_o,
  output logic                   direct_link_o
);

  localparam int unsigned NW    = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int unsigned AW    = 2 * NW;
  localparam int unsigned DEPTH = 1 << AW;
  localparam logic [DIST_WIDTH-1:0] INF   = '1;
  localparam logic [NW-1:0]         LAST  = NW'(NODES - 1);
  localparam logic [6:0]            NODES7 = 7'(NODES);

  // Storage: distance, and per pair {direct flag, transit mask}
  logic [DIST_WIDTH-1:0] dist_mem [DEPTH];
  logic [NODES:0]        mask_mem [DEPTH];

  op_e             op_q;
  logic [3:0]      src_q, dst_q;
  logic [15:0]     wt_q;
  logic [NW-1:0]   k_q, i_q, j_q;
  logic [NW-1:0]   k_d, i_d, j_d;
  logic [DIST_WIDTH-1:0] rda_q, rdb_q, sum_q, sum_d;
  logic [NODES:0]  rdm_q;
  logic [31:0]     dist_out_q;
  logic [15:0]     mask_out_q;
  logic            direct_out_q;

  logic [NW-1:0]   src_n, dst_n;
  logic            src_ok, dst_ok, ld_ok;
  logic [AW-1:0]   addr_a, addr_b, addr_m, wr_addr;
  logic            wr_en;
  logic [DIST_WIDTH-1:0] wr_dist;
  logic [NODES:0]  wr_mask;
  logic [NODES-1:0] k_bit;
  logic [DIST_WIDTH:0] wide_sum;

  // Latch the request payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_req) begin
      op_q  <= op_e'(operation_i);
      src_q <= src_node_i;
      dst_q <= dst_node_i;
      wt_q  <= link_weight_i;
    end
  end

  assign src_n  = NW'(src_q);
  assign dst_n  = NW'(dst_q);
  assign src_ok = ({3'b000, src_q} < NODES7);
  assign dst_ok = ({3'b000, dst_q} < NODES7);
  assign ld_ok  = src_ok && dst_ok && (src_q != dst_q);

  // Advance the node counters, j innermost, k outermost
  always_comb begin
    k_d = k_q;
    i_d = i_q;
    j_d = j_q;
    if (cmd_i.cnt_clr) begin
      k_d = '0;
      i_d = '0;
      j_d = '0;
    end else if (cmd_i.step_ij || cmd_i.step_kij) begin
      if (j_q != LAST) begin
        j_d = j_q + 1'b1;
      end else begin
        j_d = '0;
        if (i_q != LAST) begin
          i_d = i_q + 1'b1;
        end else begin
          i_d = '0;
          if (cmd_i.step_kij) begin
            k_d = k_q + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= '0;
      i_q <= '0;
      j_q <= '0;
    end else begin
      k_q <= k_d;
      i_q <= i_d;
      j_q <= j_d;
    end
  end

  assign sts_o.op       = op_q;
  assign sts_o.skip     = (i_q == k_q) || (j_q == k_q) || (j_q == i_q);
  assign sts_o.last_ij  = (i_q == LAST) && (j_q == LAST);
  assign sts_o.last_kij = (k_q == LAST) && (i_q == LAST) && (j_q == LAST);

  // Read addresses: the query pair unless the sweep selects otherwise
  always_comb begin
    if (cmd_i.rd_pair1) begin
      addr_a = {i_q, k_q};
    end else if (cmd_i.rd_pair2) begin
      addr_a = {i_q, j_q};
    end else begin
      addr_a = {src_n, dst_n};
    end
    addr_b = {k_q, j_q};
    addr_m = cmd_i.rd_pair2 ? {i_q, j_q} : {src_n, dst_n};
  end

  // Saturating candidate sum of d[i][k] and d[k][j]
  always_comb begin
    wide_sum = {1'b0, rda_q} + {1'b0, rdb_q};
    if (rda_q == INF || rdb_q == INF || wide_sum >= {1'b0, INF}) begin
      sum_d = INF;
    end else begin
      sum_d = wide_sum[DIST_WIDTH-1:0];
    end
  end

  assign k_bit = NODES'(1) << k_q;

  // Single write port: clear, load or relax
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = {i_q, j_q};
    wr_dist = rda_q;
    wr_mask = rdm_q;
    if (cmd_i.clr_wr) begin
      wr_en   = 1'b1;
      wr_dist = (i_q == j_q) ? '0 : INF;
      wr_mask = '0;
    end else if (cmd_i.ld_wr) begin
      wr_en   = ld_ok;
      wr_addr = {src_n, dst_n};
      wr_dist = DIST_WIDTH'(wt_q);
      wr_mask = {1'b1, {NODES{1'b0}}};
    end else if (cmd_i.upd_wr) begin
      wr_en = 1'b1;
      if (sum_q < rda_q) begin
        // shorter route through k: replace distance, mask is k alone
        wr_dist = sum_q;
        wr_mask = {1'b0, k_bit};
      end else if (sum_q == rda_q && sum_q != INF) begin
        // equal-cost route through k: add the transit bit
        wr_mask = rdm_q | {1'b0, k_bit};
      end
    end
  end

  // Memories: registered reads every cycle, one write
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      dist_mem[wr_addr] <= wr_dist;
      mask_mem[wr_addr] <= wr_mask;
    end
    rda_q <= dist_mem[addr_a];
    rdb_q <= dist_mem[addr_b];
    rdm_q <= mask_mem[addr_m];
  end

  // Hold the candidate sum for the update step
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_pair2) begin
      sum_q <= sum_d;
    end
  end

  // Query result register; out-of-range nodes read as unreachable
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if (src_ok && dst_ok) begin
        dist_out_q   <= 32'(rda_q);
        mask_out_q   <= 16'(rdm_q[NODES-1:0]);
        direct_out_q <= rdm_q[NODES];
      end else begin
        dist_out_q   <= 32'(INF);
        mask_out_q   <= '0;
        direct_out_q <= 1'b0;
      end
    end
  end

  assign distance_o     = dist_out_q;
  assign transit_mask_o = mask_out_q;
  assign direct_link_o  = direct_out_q;

endmodule

`default_nettype wire

// File: hw/rtl/ecmp_all_pairs_shortest_path.sv
// Top level of the ECMP all-pairs shortest path block.
//
// Requests enter on the input channel (in_valid_i / in_stall_o) with an
// operation, two node numbers and a link weight. Only a query gives a result,
// on the output channel (out_valid_o / out_stall_i): distance, transit mask
// and direct-link flag of one pair. Other operations give none.
// One request is worked on at a time; in_stall_o is high while busy.
// Each request is first dispatched on its latched operation, after which:
//   load writes the link; query reads the pair and loads the result register,
//   clear makes one memory write per pair,
//   run visits every triple (k, i, j), j innermost and k outermost:
//   each relaxed triple takes two reads and a write through the distance
//   memory, each triple with repeated nodes a single read step.
// After reset the block clears its memories, one write per pair, with
// in_stall_o high, before the first request is accepted.
// A result waiting under out_stall_i is held in its register; further loads,
// clears and runs proceed, and a new query waits until the register is free.
`timescale 1ns / 1ps
`default_nettype none

module ecmp_all_pairs_shortest_path
  import ecmp_apsp_pkg::*;
#(
  parameter int unsigned NODES      = 16,
  parameter int unsigned DIST_WIDTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  operation_i,
  input  wire logic [3:0]  src_node_i,
  input  wire logic [3:0]  dst_node_i,
  input  wire logic [15:0] link_weight_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      distance_o,
  output logic [15:0]      transit_mask_o,
  output logic             direct_link_o
);

  cmd_t cmd;
  sts_t sts;

  ecmp_apsp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ecmp_apsp_dpath #(
    .NODES      (NODES),
    .DIST_WIDTH (DIST_WIDTH)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .operation_i    (operation_i),
    .src_node_i     (src_node_i),
    .dst_node_i     (dst_node_i),
    .link_weight_i  (link_weight_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .distance_o     (distance_o),
    .transit_mask_o (transit_mask_o),
    .direct_link_o  (direct_link_o)
  );

  // Relaxation never writes a triple with repeated nodes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.upd_wr |-> !sts.skip)
    else $error("relaxation issued for a triple with repeated nodes");

  // A new result never overwrites one still waiting under stall
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> !(out_valid_o && out_stall_i))
    else $error("result register overwritten while stalled");

  // The sweep and the clearing pass run only while requests are held off
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.rd_pair2 || cmd.upd_wr || cmd.clr_wr) |-> in_stall_o)
    else $error("request accepted during sweep or clearing pass");

  // A relaxation step follows its two read steps
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rd_pair2 |=> cmd.upd_wr)
    else $error("relaxation step missing after reads");

endmodule

`default_nettype wire
